[hw/rtl/pixel_neighbor_pair_average_assert.svh]
// Assertion macros for the neighbor pair averaging block
`ifndef PIXEL_NEIGHBOR_PAIR_AVERAGE_ASSERT_SVH
`define PIXEL_NEIGHBOR_PAIR_AVERAGE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PNPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PNPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pnpa_pkg.sv]
// Shared constants for the neighbor pair averaging block
`default_nettype none
package pnpa_pkg;

  localparam int IDX_BITS        = 22;
  localparam int CFG_BITS        = 11;
  localparam int CFG_IDX_BITS    = 1;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // pair slots of one pixel, in emission order
  localparam int N_PAIRS      = 4;
  localparam int PAIR_DNRIGHT = 0;  // above-left pixel, its down-right pair
  localparam int PAIR_DOWN    = 1;  // pixel above, its down pair
  localparam int PAIR_DNLEFT  = 2;  // above-right pixel, its down-left pair
  localparam int PAIR_RIGHT   = 3;  // left pixel, its right pair

endpackage
`default_nettype wire

[hw/rtl/pixel_neighbor_pair_average.sv]
// Neighbor pair averaging over raster-ordered images, with a line buffer RAM
//
// Usage:
//  - in_*: one signed sample per request, raster order, images back to back.
//  - out_*: one request per neighbor pair: edge_index, pair_sum (the average
//    with one fraction bit), last_of_item on the last pair of a pixel,
//    image_end on the final pair of an image.
//  - cfg_*: write image_width (index 0) or image_height (index 1) while idle;
//    a write restarts the image at row 0, column 0. Values clamp to 2..MAX.
// A pixel's pairs are registered in the emit slot, then in the output register.
// Throughput: one pair per cycle out of the single emit slot unless the
//  output stalls; a pixel has four pairs when interior, fewer on the
//  border, none for the first pixel of an image. The next pixel is taken
//  in the cycle its predecessor hands over its last pair.
// The line buffer is read (current and next column) and written at the
//  accept edge, so every read sees all earlier pixels.
// Reset: counters restart, both dimensions read 2, line buffer keeps junk
//  (rows are always written before their values are used).
// Stall: the output register holds its request; the emit slot waits, and
//  in_ready drops until the slot can finish its pixel.
`default_nettype none
module pixel_neighbor_pair_average
  import pnpa_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_pixel_value,
  // result requests
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [IDX_BITS-1:0]    out_edge_index,
  output logic signed [SAMPLE_BITS:0]   out_pair_sum,
  output logic                          out_last_of_item,
  output logic                          out_image_end,
  // configuration writes
  input  logic                          cfg_wr_en,
  input  logic        [CFG_IDX_BITS-1:0] cfg_index,
  input  logic        [CFG_BITS-1:0]    cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SB = SAMPLE_BITS;

  // configuration
  logic [CFG_BITS-1:0] cfg_width_r, cfg_height_r;
  logic [CW:0]         wc;
  logic [RW:0]         hc;
  logic [IDX_BITS-1:0] row_len;

  // position
  logic [CW-1:0]       w_r;
  logic [RW-1:0]       h_r;
  logic [IDX_BITS-1:0] base_cur_r, base_prev_r;
  logic                last_col, last_row;

  // line buffer
  logic [SB-1:0]       row_mem [MAX_WIDTH];
  logic [SB-1:0]       above_r, above_right_r;
  logic [CW-1:0]       rd_next_addr;

  // emit slot
  logic [SB-1:0]       pix_r, left_r, above_left_r;
  logic [N_PAIRS-1:0]  mask_r, mask_new, sel, mask_left;
  logic [IDX_BITS-1:0] idx_r [N_PAIRS];
  logic [IDX_BITS-1:0] idx_new [N_PAIRS];
  logic                img_end_r;
  logic                in_fire, emit_fire;

  // output register
  logic                out_valid_r;
  logic [IDX_BITS-1:0] out_idx_r;
  logic [SB:0]         out_sum_r;
  logic                out_last_r, out_end_r;

  logic [IDX_BITS-1:0] w4, emit_idx;
  logic [SB-1:0]       emit_other;

  // clamp the dimensions
  always_comb begin
    if (cfg_width_r < CFG_BITS'(2)) begin
      wc = (CW+1)'(2);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      wc = (CW+1)'(MAX_WIDTH);
    end else begin
      wc = (CW+1)'(cfg_width_r);
    end
    if (cfg_height_r < CFG_BITS'(2)) begin
      hc = (RW+1)'(2);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      hc = (RW+1)'(MAX_HEIGHT);
    end else begin
      hc = (RW+1)'(cfg_height_r);
    end
  end

  assign row_len  = IDX_BITS'({wc, 2'b00}) - IDX_BITS'(3);
  assign last_col = ((CW+1)'(w_r) == wc - (CW+1)'(1));
  assign last_row = ((RW+1)'(h_r) == hc - (RW+1)'(1));
  assign w4       = IDX_BITS'({w_r, 2'b00});

  // handshakes
  assign emit_fire = (mask_r != '0) && (!out_valid_r || out_ready);
  assign sel       = mask_r & (~mask_r + N_PAIRS'(1));
  assign mask_left = mask_r & ~sel;
  assign in_ready  = (mask_r == '0) || (emit_fire && (mask_left == '0));
  assign in_fire   = in_valid && in_ready;

  // pairs of the arriving pixel and their positions in the edge vector
  always_comb begin
    mask_new = '0;
    mask_new[PAIR_DNRIGHT] = (h_r != '0) && (w_r != '0);
    mask_new[PAIR_DOWN]    = (h_r != '0);
    mask_new[PAIR_DNLEFT]  = (h_r != '0) && !last_col;
    mask_new[PAIR_RIGHT]   = (w_r != '0);

    idx_new[PAIR_DNRIGHT] = base_prev_r + w4 - IDX_BITS'(2);
    if (w_r == '0) begin
      idx_new[PAIR_DOWN] = base_prev_r + IDX_BITS'(1);
    end else if (last_col) begin
      idx_new[PAIR_DOWN] = base_prev_r + row_len - IDX_BITS'(1);
    end else begin
      idx_new[PAIR_DOWN] = base_prev_r + w4 + IDX_BITS'(1);
    end
    // one more step when the above-right pixel is not the row's last
    idx_new[PAIR_DNLEFT] = base_prev_r + w4 + IDX_BITS'(3)
                         + IDX_BITS'(((CW+2)'(w_r) + (CW+2)'(2)) < (CW+2)'(wc));
    if (last_row) begin
      idx_new[PAIR_RIGHT] = base_cur_r + IDX_BITS'(w_r) - IDX_BITS'(1);
    end else if (w_r == CW'(1)) begin
      idx_new[PAIR_RIGHT] = base_cur_r;
    end else begin
      idx_new[PAIR_RIGHT] = base_cur_r + w4 - IDX_BITS'(5);
    end
  end

  // config registers and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_BITS'(2);
      cfg_height_r <= CFG_BITS'(2);
      w_r          <= '0;
      h_r          <= '0;
      base_cur_r   <= '0;
      base_prev_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata;
      endcase
      w_r        <= '0;
      h_r        <= '0;
      base_cur_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        w_r <= '0;
        if (last_row) begin
          h_r        <= '0;
          base_cur_r <= '0;
        end else begin
          h_r         <= h_r + RW'(1);
          base_prev_r <= base_cur_r;
          base_cur_r  <= base_cur_r + row_len;
        end
      end else begin
        w_r <= w_r + CW'(1);
      end
    end
  end

  // line buffer: read-before-write at the accept edge
  assign rd_next_addr = last_col ? w_r : w_r + CW'(1);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_mem[w_r]  <= in_pixel_value;
      above_r       <= row_mem[w_r];
      above_right_r <= row_mem[rd_next_addr];
    end
  end

  // emit slot control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (in_fire) begin
      mask_r <= mask_new;
    end else if (emit_fire) begin
      mask_r <= mask_left;
    end
  end

  // emit slot payload; the neighbors shift along at each accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r        <= in_pixel_value;
      left_r       <= pix_r;
      above_left_r <= above_r;
      img_end_r    <= last_col && last_row;
      for (int i = 0; i < N_PAIRS; i++) begin
        idx_r[i] <= idx_new[i];
      end
    end
  end

  // pick the pending pair
  always_comb begin
    priority if (mask_r[PAIR_DNRIGHT]) begin
      emit_other = above_left_r;
      emit_idx   = idx_r[PAIR_DNRIGHT];
    end else if (mask_r[PAIR_DOWN]) begin
      emit_other = above_r;
      emit_idx   = idx_r[PAIR_DOWN];
    end else if (mask_r[PAIR_DNLEFT]) begin
      emit_other = above_right_r;
      emit_idx   = idx_r[PAIR_DNLEFT];
    end else begin
      emit_other = left_r;
      emit_idx   = idx_r[PAIR_RIGHT];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_idx_r  <= emit_idx;
      out_sum_r  <= $signed({emit_other[SB-1], emit_other}) + $signed({pix_r[SB-1], pix_r});
      out_last_r <= (mask_left == '0);
      out_end_r  <= (mask_left == '0) && img_end_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_index   = out_idx_r;
  assign out_pair_sum     = $signed(out_sum_r);
  assign out_last_of_item = out_last_r;
  assign out_image_end    = out_end_r;

  // checks
`include "pixel_neighbor_pair_average_assert.svh"

  `PNPA_ASSERT_NOW(a_pos_in_range, 1'b1,
    ((CW+1)'(w_r) < wc) && ((RW+1)'(h_r) < hc), "raster position outside image")
  `PNPA_ASSERT_NOW(a_end_is_last, out_valid_r && out_end_r, out_last_r,
    "image end on a pair that is not the pixel's last")
  `PNPA_ASSERT_NEXT(a_first_pixel_silent, in_fire && !cfg_wr_en && (w_r == '0) && (h_r == '0),
    mask_r == '0, "first pixel of an image queued pairs")

endmodule
`default_nettype wire
